// ----- sv/t16dec_pkg.sv -----
// t16dec_pkg: payload types, operation numbers and status codes for the
// thumb16 data-operation decoder. No dependencies.

package t16dec_pkg;

    typedef struct packed {
        logic [15:0] halfword;
        logic [3:0]  it_low_bits;
    } t_req;

    typedef struct packed {
        logic [4:0] operation;
        logic [3:0] dest_reg;
        logic [3:0] first_reg;
        logic [3:0] second_reg;
        logic [7:0] immediate;
        logic       set_flags;
        logic [1:0] status;
    } t_rsp;

    // status codes
    localparam logic [1:0] ST_DECODED     = 2'd0;
    localparam logic [1:0] ST_UNPREDICT   = 2'd1;
    localparam logic [1:0] ST_NOT_DECODED = 2'd2;

    // operation numbers used by name
    localparam logic [4:0] OP_ADD_REG  = 5'd3;
    localparam logic [4:0] OP_ADD_IMM3 = 5'd5;
    localparam logic [4:0] OP_MOV_IMM  = 5'd7;
    localparam logic [4:0] OP_AND      = 5'd11;
    localparam logic [4:0] OP_ADD_HIGH = 5'd27;
    localparam logic [4:0] OP_CMP_HIGH = 5'd28;
    localparam logic [4:0] OP_MOV_HIGH = 5'd29;
    localparam logic [4:0] OP_BX       = 5'd30;
    localparam logic [4:0] OP_BLX      = 5'd31;

    // data-processing sub-indices, bits 9..6
    localparam logic [3:0] DP_TST = 4'h8;
    localparam logic [3:0] DP_RSB = 4'h9;
    localparam logic [3:0] DP_CMP = 4'hA;
    localparam logic [3:0] DP_CMN = 4'hB;
    localparam logic [3:0] DP_MUL = 4'hD;
    localparam logic [3:0] DP_MVN = 4'hF;

    // register indices with a fixed role
    localparam logic [3:0] REG_SP = 4'd13;
    localparam logic [3:0] REG_PC = 4'd15;

    // IT state value marking the last instruction of a block
    localparam logic [3:0] IT_LAST = 4'h8;

endpackage

// ----- sv/t16dec_req_if.sv -----
// t16dec_req_if: valid/ready channel carrying one halfword and IT bits.
// Depends on t16dec_pkg.

interface t16dec_req_if;
    logic                valid;
    logic                ready;
    t16dec_pkg::t_req    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/t16dec_rsp_if.sv -----
// t16dec_rsp_if: valid/ready channel carrying one decoded result.
// Depends on t16dec_pkg.

interface t16dec_rsp_if;
    logic                valid;
    logic                ready;
    t16dec_pkg::t_rsp    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/thumb16_data_op_decoder.sv -----
// port    | dir | item
// i_req   | in  | halfword, it_low_bits
// o_rsp   | out | operation, dest_reg, first_reg, second_reg, immediate, set_flags, status
//
// one item per cycle sustained while o_rsp takes results; an item passes the input
// register, decode logic and result register before its result is offered on o_rsp
// reset clears both stage valids; payload registers are not reset
// a stall on o_rsp holds the result register and backs up into the input
// register; i_req.ready drops only when both stages are full
//
// thumb16_data_op_decoder: top level, registered single-pass decoder.
// Depends on t16dec_pkg, t16dec_req_if, t16dec_rsp_if.

module thumb16_data_op_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    t16dec_req_if.sink    i_req,
    t16dec_rsp_if.source  o_rsp
);
    import t16dec_pkg::*;

    logic        r_in_vld;
    t_req        r_in;
    logic        r_out_vld;
    t_rsp        r_out;
    t_rsp        n_out;

    logic        adv;
    logic [15:0] h;
    logic        in_it;
    logic        pc_bad;
    logic [3:0]  rdn;
    logic [3:0]  rm_hi;
    logic [3:0]  dp_sub;

    assign adv         = !r_out_vld || o_rsp.ready;
    assign i_req.ready = !r_in_vld || adv;
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

    assign h      = r_in.halfword;
    assign in_it  = r_in.it_low_bits != 4'h0;
    assign pc_bad = in_it && (r_in.it_low_bits != IT_LAST);
    assign rdn    = {h[7], h[2:0]};
    assign rm_hi  = h[6:3];
    assign dp_sub = h[9:6];

    always_comb begin
        n_out = '0;
        priority if (h[15:14] == 2'b00) begin
            // shift, add, subtract, move, compare
            n_out.set_flags = !in_it;
            if (!h[13] && (h[12:11] != 2'b11)) begin
                n_out.operation  = {3'b000, h[12:11]};
                n_out.dest_reg   = {1'b0, h[2:0]};
                n_out.second_reg = {1'b0, h[5:3]};
                n_out.immediate  = {3'b000, h[10:6]};
            end else if (!h[13] && !h[10]) begin
                n_out.operation  = OP_ADD_REG + {4'b0000, h[9]};
                n_out.dest_reg   = {1'b0, h[2:0]};
                n_out.first_reg  = {1'b0, h[5:3]};
                n_out.second_reg = {1'b0, h[8:6]};
            end else if (!h[13]) begin
                n_out.operation  = OP_ADD_IMM3 + {4'b0000, h[9]};
                n_out.dest_reg   = {1'b0, h[2:0]};
                n_out.first_reg  = {1'b0, h[5:3]};
                n_out.immediate  = {5'b00000, h[8:6]};
            end else begin
                n_out.operation = OP_MOV_IMM + {3'b000, h[12:11]};
                n_out.immediate = h[7:0];
                unique case (h[12:11])
                    2'b00: begin
                        n_out.dest_reg = {1'b0, h[10:8]};
                    end
                    2'b01: begin
                        n_out.first_reg = {1'b0, h[10:8]};
                        n_out.set_flags = 1'b1;
                    end
                    default: begin
                        n_out.dest_reg  = {1'b0, h[10:8]};
                        n_out.first_reg = {1'b0, h[10:8]};
                    end
                endcase
            end
        end else if (h[15:10] == 6'b010000) begin
            // register data processing
            n_out.operation = OP_AND + {1'b0, dp_sub};
            n_out.set_flags = !in_it;
            unique case (dp_sub)
                DP_TST, DP_CMP, DP_CMN: begin
                    n_out.first_reg  = {1'b0, h[2:0]};
                    n_out.second_reg = {1'b0, h[5:3]};
                    n_out.set_flags  = 1'b1;
                end
                DP_RSB: begin
                    n_out.dest_reg  = {1'b0, h[2:0]};
                    n_out.first_reg = {1'b0, h[5:3]};
                end
                DP_MUL: begin
                    n_out.dest_reg   = {1'b0, h[2:0]};
                    n_out.second_reg = {1'b0, h[2:0]};
                    n_out.first_reg  = {1'b0, h[5:3]};
                end
                DP_MVN: begin
                    n_out.dest_reg   = {1'b0, h[2:0]};
                    n_out.second_reg = {1'b0, h[5:3]};
                end
                default: begin
                    n_out.dest_reg   = {1'b0, h[2:0]};
                    n_out.first_reg  = {1'b0, h[2:0]};
                    n_out.second_reg = {1'b0, h[5:3]};
                end
            endcase
        end else if (h[15:10] == 6'b010001) begin
            // special data and branch exchange
            unique case (h[9:8])
                2'b00: begin
                    n_out.operation = OP_ADD_HIGH;
                    if (rm_hi == REG_SP) begin
                        n_out.dest_reg   = rdn;
                        n_out.first_reg  = REG_SP;
                        n_out.second_reg = rdn;
                        if (rdn == REG_PC && pc_bad) n_out.status = ST_UNPREDICT;
                    end else if (rdn == REG_SP) begin
                        n_out.dest_reg   = REG_SP;
                        n_out.first_reg  = REG_SP;
                        n_out.second_reg = rm_hi;
                    end else begin
                        n_out.dest_reg   = rdn;
                        n_out.first_reg  = rdn;
                        n_out.second_reg = rm_hi;
                        if (rdn == REG_PC && (pc_bad || rm_hi == REG_PC))
                            n_out.status = ST_UNPREDICT;
                    end
                end
                2'b01: begin
                    n_out.operation  = OP_CMP_HIGH;
                    n_out.first_reg  = rdn;
                    n_out.second_reg = rm_hi;
                    n_out.set_flags  = 1'b1;
                    if ((!rdn[3] && !rm_hi[3]) || (rdn == REG_PC && rm_hi == REG_PC))
                        n_out.status = ST_UNPREDICT;
                end
                2'b10: begin
                    n_out.operation  = OP_MOV_HIGH;
                    n_out.dest_reg   = rdn;
                    n_out.second_reg = rm_hi;
                    if (rdn == REG_PC && pc_bad) n_out.status = ST_UNPREDICT;
                end
                default: begin
                    n_out.operation  = h[7] ? OP_BLX : OP_BX;
                    n_out.dest_reg   = REG_PC;
                    n_out.second_reg = rm_hi;
                    if (h[2:0] != 3'b000 || pc_bad) n_out.status = ST_UNPREDICT;
                end
            endcase
            // unpredictable forms never update flags
            if (n_out.status != ST_DECODED) n_out.set_flags = 1'b0;
        end else begin
            n_out.status = ST_NOT_DECODED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_req.ready) r_in_vld <= i_req.valid;
            if (adv) r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) r_in <= i_req.data;
        if (adv && r_in_vld) r_out <= n_out;
    end

    a_accept_fills_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_in_vld)
        else $error("accepted item did not reach the input register");

    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && adv |=> r_out_vld)
        else $error("decoded item did not reach the result register");

    a_nodec_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.status == ST_NOT_DECODED |->
            r_out.operation == 5'd0 && r_out.dest_reg == 4'd0 &&
            r_out.first_reg == 4'd0 && r_out.second_reg == 4'd0 &&
            r_out.immediate == 8'd0 && !r_out.set_flags)
        else $error("undecoded group carries nonzero fields");

    a_unpred_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.status == ST_UNPREDICT |->
            !r_out.set_flags && r_out.operation >= OP_ADD_HIGH)
        else $error("unpredictable result sets flags or is outside special group");

endmodule

// ----- tb/tb_thumb16_data_op_decoder.sv -----
// tb_thumb16_data_op_decoder: self-checking bench for the thumb16 data-op decoder.
// Depends on t16dec_pkg, t16dec_req_if, t16dec_rsp_if and thumb16_data_op_decoder.
`timescale 1ns / 100ps

module tb_thumb16_data_op_decoder;
    import t16dec_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RESET_CYCLES = 6;

    // bits 15..10 of the halfword
    localparam logic [5:0] GRP_DATA    = 6'h10;
    localparam logic [5:0] GRP_SPECIAL = 6'h11;

    // bits 12..11 of the 8-bit immediate forms
    localparam logic [1:0] IMM8_MOV = 2'd0;
    localparam logic [1:0] IMM8_CMP = 2'd1;

    typedef struct {
        t_req item;
        t_rsp want;
    } t_decode_entry;

    logic clk;
    logic rst_n;
    logic rsp_hold;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_len;
    int   mismatch_count;
    int   cycle_count;
    event hold_go;

    t_decode_entry expected_decodes[$];

    t16dec_req_if req_if();
    t16dec_rsp_if rsp_if();

    thumb16_data_op_decoder DUT (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic t_rsp predict_decode(input logic [15:0] hw, input logic [3:0] it);
        t_rsp       r;
        logic       in_it;
        logic       pc_bad;
        logic [4:0] sub5;
        logic [3:0] sub4;
        logic [3:0] rdn;
        logic [3:0] rm;
        r      = '0;
        in_it  = (it != 4'h0);
        pc_bad = in_it && (it != IT_LAST);
        sub5   = hw[13:9];
        sub4   = hw[9:6];
        rdn    = {hw[7], hw[2:0]};
        rm     = hw[6:3];
        if (hw[15:14] == 2'b00) begin
            r.set_flags = !in_it;
            if (sub5 < 5'd12) begin
                r.operation  = {2'b00, sub5[4:2]};
                r.dest_reg   = 4'(hw[2:0]);
                r.second_reg = 4'(hw[5:3]);
                r.immediate  = 8'(hw[10:6]);
            end else if (sub5 < 5'd14) begin
                r.operation  = OP_ADD_REG + 5'(sub5[0]);
                r.dest_reg   = 4'(hw[2:0]);
                r.first_reg  = 4'(hw[5:3]);
                r.second_reg = 4'(hw[8:6]);
            end else if (sub5 < 5'd16) begin
                r.operation = OP_ADD_IMM3 + 5'(sub5[0]);
                r.dest_reg  = 4'(hw[2:0]);
                r.first_reg = 4'(hw[5:3]);
                r.immediate = 8'(hw[8:6]);
            end else begin
                r.operation = OP_MOV_IMM + 5'(sub5[3:2]);
                r.immediate = hw[7:0];
                case (sub5[3:2])
                    IMM8_MOV: begin
                        r.dest_reg = 4'(hw[10:8]);
                    end
                    IMM8_CMP: begin
                        r.first_reg = 4'(hw[10:8]);
                        r.set_flags = 1'b1;
                    end
                    default: begin
                        r.dest_reg  = 4'(hw[10:8]);
                        r.first_reg = 4'(hw[10:8]);
                    end
                endcase
            end
        end else if (hw[15:10] == GRP_DATA) begin
            r.operation = OP_AND + 5'(sub4);
            r.set_flags = !in_it;
            case (sub4)
                DP_TST, DP_CMP, DP_CMN: begin
                    r.first_reg  = 4'(hw[2:0]);
                    r.second_reg = 4'(hw[5:3]);
                    r.set_flags  = 1'b1;
                end
                DP_RSB: begin
                    r.dest_reg  = 4'(hw[2:0]);
                    r.first_reg = 4'(hw[5:3]);
                end
                DP_MUL: begin
                    r.dest_reg   = 4'(hw[2:0]);
                    r.second_reg = 4'(hw[2:0]);
                    r.first_reg  = 4'(hw[5:3]);
                end
                DP_MVN: begin
                    r.dest_reg   = 4'(hw[2:0]);
                    r.second_reg = 4'(hw[5:3]);
                end
                default: begin
                    r.dest_reg   = 4'(hw[2:0]);
                    r.first_reg  = 4'(hw[2:0]);
                    r.second_reg = 4'(hw[5:3]);
                end
            endcase
        end else if (hw[15:10] == GRP_SPECIAL) begin
            if (sub4 < 4'd4) begin
                r.operation = OP_ADD_HIGH;
                if (rm == REG_SP) begin
                    // add rdm, sp, rdm
                    r.dest_reg   = rdn;
                    r.first_reg  = REG_SP;
                    r.second_reg = rdn;
                    if (rdn == REG_PC && pc_bad)
                        r.status = ST_UNPREDICT;
                end else if (rdn == REG_SP) begin
                    r.dest_reg   = REG_SP;
                    r.first_reg  = REG_SP;
                    r.second_reg = rm;
                end else begin
                    r.dest_reg   = rdn;
                    r.first_reg  = rdn;
                    r.second_reg = rm;
                    if (rdn == REG_PC && (pc_bad || rm == REG_PC))
                        r.status = ST_UNPREDICT;
                end
            end else if (sub4 < 4'd8) begin
                r.operation  = OP_CMP_HIGH;
                r.first_reg  = rdn;
                r.second_reg = rm;
                r.set_flags  = 1'b1;
                if ((rdn < 4'd8 && rm < 4'd8) || (rdn == REG_PC && rm == REG_PC))
                    r.status = ST_UNPREDICT;
            end else if (sub4 < 4'd12) begin
                r.operation  = OP_MOV_HIGH;
                r.dest_reg   = rdn;
                r.second_reg = rm;
                if (rdn == REG_PC && pc_bad)
                    r.status = ST_UNPREDICT;
            end else begin
                r.operation  = (sub4 < 4'd14) ? OP_BX : OP_BLX;
                r.dest_reg   = REG_PC;
                r.second_reg = rm;
                if (hw[2:0] != 3'd0 || pc_bad)
                    r.status = ST_UNPREDICT;
            end
            if (r.status != ST_DECODED)
                r.set_flags = 1'b0;
        end else begin
            r.status = ST_NOT_DECODED;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input t_req item,
                               input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("hw %04h it %h %s got %0h want %0h",
                                      item.halfword, item.it_low_bits, name, got, want));
    endtask

    task automatic check_result(input t_rsp got);
        t_decode_entry e;
        if (expected_decodes.size() == 0) begin
            report_mismatch($sformatf("result %h with no item pending", got));
        end else begin
            e = expected_decodes.pop_front();
            check_field("operation",  e.item, 8'(got.operation),  8'(e.want.operation));
            check_field("dest_reg",   e.item, 8'(got.dest_reg),   8'(e.want.dest_reg));
            check_field("first_reg",  e.item, 8'(got.first_reg),  8'(e.want.first_reg));
            check_field("second_reg", e.item, 8'(got.second_reg), 8'(e.want.second_reg));
            check_field("immediate",  e.item, got.immediate,      e.want.immediate);
            check_field("set_flags",  e.item, 8'(got.set_flags),  8'(e.want.set_flags));
            check_field("status",     e.item, 8'(got.status),     8'(e.want.status));
        end
    endtask

    // result side: check on every accepted item, then pick next ready
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
                check_result(rsp_if.data);
            rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long hold-off of the result side, counted here
    initial begin
        rsp_hold = 1'b0;
        forever begin
            @(hold_go);
            rsp_hold <= 1'b1;
            repeat (hold_len) @(posedge clk);
            rsp_hold <= 1'b0;
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL thumb16_data_op_decoder");
        $finish;
    end

    // called just after a rising edge; returns at the edge that took the item
    task automatic send_item(input logic [15:0] hw, input logic [3:0] it);
        t_req          item;
        t_decode_entry e;
        item.halfword    = hw;
        item.it_low_bits = it;
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        e.item = item;
        e.want = predict_decode(hw, it);
        expected_decodes.push_back(e);
    endtask

    function automatic logic [15:0] random_halfword();
        logic [31:0] bits;
        logic [15:0] hw;
        int          pick;
        bits = $urandom();
        hw   = bits[15:0];
        pick = $urandom_range(19);
        if (pick < 9) begin
            hw[15:14] = 2'b00;
        end else if (pick < 13) begin
            hw[15:10] = GRP_DATA;
        end else if (pick < 19) begin
            hw[15:10] = GRP_SPECIAL;
            // lean on sp and pc, where the special cases live
            if (bits[16])
                hw[6:3] = bits[17] ? REG_PC : REG_SP;
            if (bits[18])
                {hw[7], hw[2:0]} = bits[19] ? REG_PC : REG_SP;
            if (hw[9:8] == 2'b11 && bits[20])
                hw[2:0] = 3'd0;
        end
        return hw;
    endfunction

    function automatic logic [3:0] random_it_bits();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4)
            return 4'h0;
        else if (pick < 6)
            return IT_LAST;
        else
            return 4'($urandom_range(15));
    endfunction

    task automatic test_shift_add_sub_mov();
        send_item(16'h0000, 4'h0);       // lsl r0, r0, #0
        send_item(16'h07FF, 4'hF);       // lsl r7, r7, #31 in it block
        send_item(16'h083A, IT_LAST);    // lsr
        send_item(16'h17FF, 4'h0);       // asr
        send_item(16'h19FF, 4'h1);       // add reg
        send_item(16'h1A00, 4'h0);       // sub reg
        send_item(16'h1DFF, 4'h0);       // add imm3
        send_item(16'h1E00, 4'h8);       // sub imm3
        send_item(16'h27FF, 4'h0);       // mov imm, full 8-bit field
        send_item(16'h2880, 4'h4);       // cmp imm sets flags in it block
        send_item(16'h37FF, 4'h0);       // add imm8
        send_item(16'h3F01, 4'h2);       // sub imm8
    endtask

    task automatic test_data_processing();
        for (int k = 0; k < 16; k++)
            send_item({GRP_DATA, 4'(k), 3'(k), 3'(7 - k)}, k[0] ? 4'h4 : 4'h0);
    endtask

    task automatic test_special_data();
        send_item(16'h4449, 4'h0);       // add r1, r9
        send_item(16'h44EF, 4'h4);       // add pc, sp, pc inside it, not last
        send_item(16'h44A5, 4'h0);       // add sp, sp, r4
        send_item(16'h44FF, 4'h0);       // add pc, pc
        send_item(16'h4497, IT_LAST);    // add pc, r2 as last of it block
        send_item(16'h4511, 4'h0);       // cmp sub-index four, both low
        send_item(16'h4599, 4'h6);       // cmp r9, r3
        send_item(16'h45FF, 4'h0);       // cmp pc, pc
        send_item(16'h4687, 4'h2);       // mov pc inside it, not last
        send_item(16'h46F0, 4'h0);       // mov r8, lr
        send_item(16'h4770, 4'h0);       // bx lr
        send_item(16'h4771, 4'h0);       // bx with low bits set
        send_item(16'h4798, IT_LAST);    // blx r3 last in it block
        send_item(16'h4798, 4'h1);       // blx r3 inside it, not last
    endtask

    task automatic test_other_groups();
        send_item(16'h4800, 4'h0);
        send_item(16'hFFFF, 4'hF);
    endtask

    task automatic test_random_items(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_item(random_halfword(), random_it_bits());
    endtask

    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_len      = 150;
        -> hold_go;
        repeat (40) send_item(random_halfword(), random_it_bits());
    endtask

    initial begin
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.data    <= '0;
        mismatch_count = 0;
        send_idle_pct  = 38;
        recv_idle_pct  = 81;
        hold_len       = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_shift_add_sub_mov();
        test_data_processing();
        test_special_data();
        test_other_groups();
        test_random_items(230, 38, 81);
        test_random_items(230, 81, 38);
        test_output_stall();
        test_random_items(200, 0, 0);

        req_if.valid <= 1'b0;
        while (expected_decodes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS thumb16_data_op_decoder");
        else
            $display("FAIL thumb16_data_op_decoder");
        $finish;
    end

endmodule
